[rtl/core/tedds_pkg.sv]
// ----------------------------------------------------------------------------
// Edge DDA setup package
// Field widths, beat layouts and defaults shared by the edge setup pipeline.
// ----------------------------------------------------------------------------
package tedds_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 192;

    // declared last field first so the first field lands in the lowest bits
    typedef struct packed {
        logic signed [31:0] start_x;
        logic        [30:0] y_offset;
        logic signed [31:0] edge_width;
        logic        [30:0] edge_height;
    } in_t;

    typedef struct packed {
        logic signed [31:0] initial_error;
        logic        [30:0] step_rem;
        logic signed [31:0] step_whole;
        logic signed [31:0] adjusted_x;
        logic        [30:0] slope_rem;
        logic signed [31:0] slope_whole;
    } out_t;

endpackage

[rtl/core/tedds_core.sv]
// ----------------------------------------------------------------------------
// Edge DDA setup datapath
// One-bit-per-stage floor division, fraction division, wrapped multiply-add
// and bit-serial modular product, all in one lock-step register pipeline.
// ----------------------------------------------------------------------------
module tedds_core #(
    parameter int FRAC_BITS = tedds_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = tedds_pkg::WORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             en,
    input  tedds_pkg::in_t   din,
    output tedds_pkg::out_t  dout
);
    import tedds_pkg::*;

    localparam int QW     = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int DIV_N  = 32;
    localparam int FIX_S  = DIV_N;
    localparam int HOR_N  = 31;
    localparam int LAST   = FIX_S + 1 + HOR_N;

    typedef struct packed {
        logic [30:0]        h;
        logic [30:0]        ys;
        logic [31:0]        x;
        logic               neg;
        logic [31:0]        dvd;
        logic [30:0]        rem;
        logic [31:0]        q;
        logic [30:0]        r;
        logic [63:0]        prod;
        logic [31:0]        ax;
        logic [30:0]        frem;
        logic [QW-1:0]      fquo;
        logic [30:0]        acc;
    } stage_t;

    function automatic logic [31:0] wrap32(input logic [63:0] v);
        logic [63:0] w;
        for (int i = 0; i < 64; i++)
        begin
            w[i] = (i < WORD_BITS) ? v[i] : v[WORD_BITS-1];
        end
        return w[31:0];
    endfunction

    stage_t p_reg [0:LAST];
    stage_t p_next [0:LAST];
    out_t   o_reg;
    out_t   o_next;

    // capture and take magnitude
    always_comb
    begin
        p_next[0]      = '0;
        p_next[0].h    = din.edge_height;
        p_next[0].ys   = din.y_offset;
        p_next[0].x    = din.start_x;
        p_next[0].neg  = din.edge_width[31];
        p_next[0].dvd  = din.edge_width[31] ? (32'd0 - din.edge_width) : din.edge_width;
    end

    genvar g;
    generate
        for (g = 0; g < LAST; g++)
        begin : g_stage
            if (g < DIV_N)
            begin : g_div
                logic [31:0] t;
                logic        bit_q;
                always_comb
                begin
                    t          = {p_reg[g].rem, p_reg[g].dvd[31]};
                    bit_q      = (t >= {1'b0, p_reg[g].h});
                    p_next[g+1]     = p_reg[g];
                    p_next[g+1].rem = bit_q ? 31'(t - {1'b0, p_reg[g].h}) : t[30:0];
                    p_next[g+1].dvd = {p_reg[g].dvd[30:0], bit_q};
                end
            end
            else if (g == FIX_S)
            begin : g_fix
                always_comb
                begin
                    p_next[g+1] = p_reg[g];
                    if (!p_reg[g].neg)
                    begin
                        p_next[g+1].q = p_reg[g].dvd;
                        p_next[g+1].r = p_reg[g].rem;
                    end
                    else if (p_reg[g].rem == '0)
                    begin
                        p_next[g+1].q = 32'd0 - p_reg[g].dvd;
                        p_next[g+1].r = '0;
                    end
                    else
                    begin
                        p_next[g+1].q = ~p_reg[g].dvd;
                        p_next[g+1].r = p_reg[g].h - p_reg[g].rem;
                    end
                    p_next[g+1].frem = p_next[g+1].r;
                    p_next[g+1].fquo = '0;
                    p_next[g+1].acc  = '0;
                end
            end
            else
            begin : g_hor
                localparam int J = g - FIX_S - 1;
                logic [31:0] a;
                logic [31:0] b;
                logic [31:0] ft;
                logic        fbit;
                always_comb
                begin
                    p_next[g+1] = p_reg[g];
                    a = {p_reg[g].acc, 1'b0};
                    if (a >= {1'b0, p_reg[g].h})
                    begin
                        a = a - {1'b0, p_reg[g].h};
                    end
                    b = a + (p_reg[g].ys[30-J] ? {1'b0, p_reg[g].r} : 32'd0);
                    if (b >= {1'b0, p_reg[g].h})
                    begin
                        b = b - {1'b0, p_reg[g].h};
                    end
                    p_next[g+1].acc = b[30:0];
                    ft   = {p_reg[g].frem, 1'b0};
                    fbit = (ft >= {1'b0, p_reg[g].h});
                    if (J < FRAC_BITS)
                    begin
                        p_next[g+1].frem = fbit ? 31'(ft - {1'b0, p_reg[g].h}) : ft[30:0];
                        p_next[g+1].fquo = (p_reg[g].fquo << 1) | QW'(fbit);
                    end
                    if (J == 0)
                    begin
                        p_next[g+1].prod = 64'($signed({1'b0, p_reg[g].ys}))
                                           * 64'($signed(p_reg[g].q));
                    end
                    if (J == 1)
                    begin
                        p_next[g+1].ax = wrap32(64'($signed(p_reg[g].x)) + p_reg[g].prod);
                    end
                end
            end
        end
    endgenerate

    // finish step and vertical terms, force zero height
    always_comb
    begin
        logic [63:0] sw;
        sw = (64'($signed(p_reg[LAST].q)) << FRAC_BITS)
             + ((FRAC_BITS > 0) ? 64'(p_reg[LAST].fquo) : 64'd0);
        o_next.slope_whole   = p_reg[LAST].q;
        o_next.slope_rem     = p_reg[LAST].r;
        o_next.adjusted_x    = p_reg[LAST].ax;
        o_next.step_whole    = wrap32(sw);
        o_next.step_rem      = p_reg[LAST].frem;
        o_next.initial_error = {1'b0, p_reg[LAST].acc} - {1'b0, p_reg[LAST].h};
        if (p_reg[LAST].h == '0)
        begin
            o_next               = '0;
            o_next.adjusted_x    = p_reg[LAST].x;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                p_reg[i] <= p_next[i];
            end
            o_reg <= o_next;
        end
    end

    assign dout = o_reg;

endmodule

[rtl/core/trapezoid_edge_dda_setup.sv]
// ----------------------------------------------------------------------------
// Trapezoid edge DDA setup
// Splits an edge slope into whole and remainder stepping terms per beat.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents (low bit up)
//  s_axis    in   edge_height, edge_width, y_offset, start_x
//  m_axis    out  slope_whole, slope_rem, adjusted_x, step_whole, step_rem,
//                 initial_error
//
//  One beat per cycle while no output beat is held; a beat passes the 32 one-bit
//  stages of the slope division and then the 31 one-bit stages of the modular product.
//  Reset clears only the valid bits; no clearing pass.
//  A held output beat freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module trapezoid_edge_dda_setup #(
    parameter int FRAC_BITS = tedds_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = tedds_pkg::WORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // edge_height, edge_width, y_offset, start_x, zero pad
    input  logic [tedds_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // slope_whole, slope_rem, adjusted_x, step_whole, step_rem, initial_error,
    // zero pad
    output logic [tedds_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import tedds_pkg::*;

    localparam int DEPTH = 66;

    logic [DEPTH-1:0] vld_reg;
    logic             en;
    in_t              din;
    out_t             dout;

    assign en       = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign din      = in_t'(s_tdata[$bits(in_t)-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    tedds_core #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk  (clk),
        .en   (en),
        .din  (din),
        .dout (dout)
    );

    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tdata  = {(OUT_TDATA_W - $bits(out_t))'(0), dout};

endmodule

[rtl/core/tedds_checker.sv]
// ----------------------------------------------------------------------------
// Edge DDA setup port checker
// Watches the stream ports of the edge setup block over time.
// ----------------------------------------------------------------------------
module tedds_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);

    a_rst_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output beat valid in reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("held output beat changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline frozen");

    a_err_neg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[189] || m_tdata[189:158] == 32'd0))
        else $error("initial error not negative");

endmodule

bind trapezoid_edge_dda_setup tedds_checker u_tedds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/tb_trapezoid_edge_dda_setup.sv]
// ----------------------------------------------------------------------------
// Trapezoid edge DDA setup testbench
// Drives edge beats through the stream input with random gaps, predicts the
// slope, start x, per-scanline step and initial error terms of every edge, and
// compares each output beat field by field against the oldest prediction.
// A short table of edge cases comes first, then random edges.
// ----------------------------------------------------------------------------
module tb_trapezoid_edge_dda_setup;
    import tedds_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int N_RANDOM  = 700;
    localparam int LIMIT     = 400000;
    localparam int DRAIN     = 80;

    typedef struct packed {
        logic        [30:0] h;
        logic signed [31:0] w;
        logic        [30:0] ys;
        logic signed [31:0] x;
        bit                 typed;
        logic signed [31:0] e_slope;
        logic signed [31:0] e_adj;
        logic signed [31:0] e_step;
        logic signed [31:0] e_err;
    } edge_row_t;

    localparam int N_DIR = 16;
    localparam edge_row_t EDGE_TABLE [N_DIR] = '{
        '{31'd0, 32'sd5, 31'd9, 32'sd77, 1'b1, 32'sd0, 32'sd77, 32'sd0, 32'sd0},
        '{31'd0, -32'sd1, 31'h7fffffff, 32'sh80000000, 1'b1, 32'sd0, 32'sh80000000,
          32'sd0, 32'sd0},
        '{31'd1, 32'sd0, 31'd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0, -32'sd1},
        '{31'd1, 32'sd5, 31'd3, 32'sd10, 1'b1, 32'sd5, 32'sd25, 32'sd1280, -32'sd1},
        '{31'd4, 32'sd12, 31'd2, -32'sd1, 1'b1, 32'sd3, 32'sd5, 32'sd768, -32'sd4},
        '{31'h7fffffff, 32'sh80000000, 31'd0, 32'sd0, 1'b0, 0, 0, 0, 0},
        '{31'h7fffffff, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000, 1'b0, 0, 0, 0, 0},
        '{31'd1, 32'sh7fffffff, 31'h7fffffff, 32'sh7fffffff, 1'b0, 0, 0, 0, 0},
        '{31'd1, 32'sh80000000, 31'h7fffffff, 32'sh80000000, 1'b0, 0, 0, 0, 0},
        '{31'd3, -32'sd1, 31'd1, 32'sd0, 1'b0, 0, 0, 0, 0},
        '{31'd7, -32'sd22, 31'd5, 32'sd100, 1'b0, 0, 0, 0, 0},
        '{31'd256, 32'sd255, 31'd300, -32'sd5, 1'b0, 0, 0, 0, 0},
        '{31'h40000000, 32'sh3fffffff, 31'h7ffffffe, 32'sd1, 1'b0, 0, 0, 0, 0},
        '{31'h7ffffffe, -32'sd3, 31'h55555555, 32'sh2aaaaaaa, 1'b0, 0, 0, 0, 0},
        '{31'd3, 32'sh55555555, 31'h2aaaaaaa, 32'sh55555555, 1'b0, 0, 0, 0, 0},
        '{31'd2, 32'sd1, 31'd1, 32'sd0, 1'b0, 0, 0, 0, 0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    out_t pending_terms [$];
    int   n_fail;
    int   n_beats_in;
    int   n_beats_out;
    int   n_zero_h;
    int   cycles;

    trapezoid_edge_dda_setup u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic out_t edge_terms(in_t e);
        out_t   t;
        longint h;
        longint q;
        longint r;
        longint ys;
        longint scaled;
        h  = longint'(e.edge_height);
        ys = longint'(e.y_offset);
        t  = '0;
        if (h == 0)
        begin
            t.adjusted_x = e.start_x;
            return t;
        end
        q = longint'(e.edge_width) / h;
        r = longint'(e.edge_width) % h;
        if (r < 0)
        begin
            q = q - 1;
            r = r + h;
        end
        scaled          = r << FRAC;
        t.slope_whole   = q[31:0];
        t.slope_rem     = r[30:0];
        t.adjusted_x    = 32'(longint'(e.start_x) + ys * q);
        t.step_whole    = 32'(q * (64'sd1 <<< FRAC) + scaled / h);
        t.step_rem      = 31'(scaled % h);
        t.initial_error = 32'(((ys * r) % h) - h);
        return t;
    endfunction

    function automatic int draw_wait(ref int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            quiet_left = $urandom_range(10, 40);
        return $urandom_range(0, 12);
    endfunction

    task automatic send_edge(in_t e, out_t exp_t, ref int quiet_left);
        int gap;
        gap = draw_wait(quiet_left);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - $bits(in_t)){1'b0}}, e};
        do @(posedge clk); while (!s_tready);
        pending_terms.push_back(exp_t);
        n_beats_in++;
        if (e.edge_height == 0)
            n_zero_h++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_terms.size() != 0) @(posedge clk);
    endtask

    function automatic logic [30:0] pick_height();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 7) == 0) ? 31'd0 : 31'h7fffffff;
            1, 2:    return 31'($urandom_range(1, 16));
            3, 4:    return 31'($urandom_range(1, 4095));
            5:       return 31'd1 << $urandom_range(0, 30);
            default: return 31'($urandom) | 31'd1;
        endcase
    endfunction

    function automatic logic [30:0] pick_offset();
        case ($urandom_range(0, 3))
            0:       return 31'($urandom_range(0, 255));
            1:       return 31'($urandom_range(0, 65535));
            default: return 31'($urandom);
        endcase
    endfunction

    initial
    begin
        in_t  e;
        out_t exp_t;
        int   quiet_left;
        quiet_left = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            e.edge_height = EDGE_TABLE[i].h;
            e.edge_width  = EDGE_TABLE[i].w;
            e.y_offset    = EDGE_TABLE[i].ys;
            e.start_x     = EDGE_TABLE[i].x;
            if (EDGE_TABLE[i].typed)
            begin
                exp_t               = '0;
                exp_t.slope_whole   = EDGE_TABLE[i].e_slope;
                exp_t.adjusted_x    = EDGE_TABLE[i].e_adj;
                exp_t.step_whole    = EDGE_TABLE[i].e_step;
                exp_t.initial_error = EDGE_TABLE[i].e_err;
            end
            else
                exp_t = edge_terms(e);
            send_edge(e, exp_t, quiet_left);
        end
        hold_until_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            e.edge_height = pick_height();
            e.y_offset    = pick_offset();
            e.start_x     = $urandom;
            case ($urandom_range(0, 3))
                0:       e.edge_width = $signed(32'($urandom_range(0, 8191))) - 32'sd4096;
                1:       e.edge_width = $signed(e.edge_height) * $signed(32'($urandom_range(0, 6)) - 3);
                default: e.edge_width = $urandom;
            endcase
            send_edge(e, edge_terms(e), quiet_left);
            if (i == N_RANDOM / 2)
                hold_until_drained();
        end
        hold_until_drained();
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d edges (%0d of zero height), checked %0d result beats.",
                 n_beats_in, n_zero_h, n_beats_out);
        $display("Random gaps and back-pressure on both channels, with drain pauses.");
        if (n_fail == 0 && pending_terms.size() == 0)
            $display("** trapezoid_edge_dda_setup: PASSED **");
        else
            $display("** trapezoid_edge_dda_setup: FAILED **");
        $finish;
    end

    initial
    begin
        int stall;
        int quiet_left;
        quiet_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(quiet_left);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge clk)
    begin
        out_t got;
        out_t exp_t;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(out_t)-1:0];
            n_beats_out++;
            if (pending_terms.size() == 0)
            begin
                $error("result beat with no edge outstanding");
                n_fail++;
            end
            else
            begin
                exp_t = pending_terms.pop_front();
                check_field("slope_whole", exp_t.slope_whole, got.slope_whole);
                check_field("slope_rem", exp_t.slope_rem, got.slope_rem);
                check_field("adjusted_x", exp_t.adjusted_x, got.adjusted_x);
                check_field("step_whole", exp_t.step_whole, got.step_whole);
                check_field("step_rem", exp_t.step_rem, got.step_rem);
                check_field("initial_error", exp_t.initial_error, got.initial_error);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Timed out with %0d results outstanding.", pending_terms.size());
            $display("** trapezoid_edge_dda_setup: FAILED **");
            $finish;
        end
    end

endmodule

[files.f]
rtl/core/tedds_pkg.sv
rtl/core/tedds_core.sv
rtl/core/trapezoid_edge_dda_setup.sv
rtl/core/tedds_checker.sv
dv/tb_trapezoid_edge_dda_setup.sv
